@@ rtl/ppt_pkg.sv @@
// Package for the priority process table: payload word types, action and
// status codes, slot state codes and default sizes.
// No dependencies.
`default_nettype none
package ppt_pkg;

   localparam int NUM_SLOTS_DEF = 64;
   localparam int PID_BITS_DEF  = 16;
   localparam logic [6:0] DEFAULT_PRIORITY_RESET = 7'd5;
   localparam logic [5:0] INIT_SLOT_RESET        = 6'd0;

   localparam logic [3:0] ACT_CREATE   = 4'd0;
   localparam logic [3:0] ACT_SCHEDULE = 4'd1;
   localparam logic [3:0] ACT_YIELD    = 4'd2;
   localparam logic [3:0] ACT_SLEEP    = 4'd3;
   localparam logic [3:0] ACT_WAKEUP   = 4'd4;
   localparam logic [3:0] ACT_KILL     = 4'd5;
   localparam logic [3:0] ACT_SETPRIO  = 4'd6;
   localparam logic [3:0] ACT_EXIT     = 4'd7;
   localparam logic [3:0] ACT_WAIT     = 4'd8;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FAIL      = 2'd1;
   localparam logic [1:0] STAT_INIT_EXIT = 2'd2;
   localparam logic [1:0] STAT_SLEEPING  = 2'd3;

   localparam logic CSR_DEFAULT_PRIORITY = 1'b0;
   localparam logic CSR_INIT_SLOT        = 1'b1;

   typedef enum logic [1:0] {
      SLOT_RUNNABLE,
      SLOT_RUNNING,
      SLOT_SLEEPING,
      SLOT_ZOMBIE
   } slot_state_type;

   typedef struct packed {
      logic [3:0]        action;
      logic [5:0]        slot;
      logic              has_parent;
      logic [15:0]       target_pid;
      logic signed [7:0] new_priority;
      logic [15:0]       channel;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_slot;
      logic [15:0] result_pid;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } store_ctl_type;

endpackage
`default_nettype wire

@@ rtl/ppt_store.sv @@
// Slot table storage: one memory of slot entries with a registered read port
// and one write port, plus a flip-flop in-use flag for each slot.
// Depends on ppt_pkg.
`default_nettype none
module ppt_store #(
   parameter int NUM_SLOTS = ppt_pkg::NUM_SLOTS_DEF,
   parameter int ENTRY_W   = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output logic      [ENTRY_W-1:0]           rd_data,
   input  wire ppt_pkg::store_ctl_type       ctl,
   input  wire logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  wire logic [ENTRY_W-1:0]           wr_data,
   output logic      [NUM_SLOTS-1:0]         valid
);

   logic [ENTRY_W-1:0]   mem_ff [NUM_SLOTS];
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic [NUM_SLOTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.set_valid) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (ctl.clr_valid) begin
         valid_ff[wr_addr] <= 1'b0;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule
`default_nettype wire

@@ rtl/priority_process_table.sv @@
// An action that touches only the caller's slot needs no pass over the table;
// any other makes one pass over it at one slot per cycle through the single
// read port of the slot memory; exit makes a reparenting pass and then a
// wakeup pass.
// One word is in work at a time; req_stall is high from acceptance until the
// result word has been taken. No clearing pass is needed after reset.
// Top level of the priority process table. Depends on ppt_pkg and ppt_store.
`default_nettype none
module priority_process_table #(
   parameter int NUM_SLOTS = ppt_pkg::NUM_SLOTS_DEF,
   parameter int PID_BITS  = ppt_pkg::PID_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ppt_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ppt_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [6:0]       csr_wdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int PAR_W = $clog2(NUM_SLOTS + 1);
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam logic [PID_BITS-1:0] PID_MAX = {PID_BITS{1'b1}};

   typedef struct packed {
      ppt_pkg::slot_state_type st;
      logic [PID_BITS-1:0]     pid;
      logic [6:0]              prio;
      logic [PAR_W-1:0]        parent;
      logic [15:0]             chan;
      logic                    killed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FINAL,
      S_DONE
   } fsm_type;

   fsm_type          state_ff, state_in;
   ppt_pkg::req_type req_ff, req_in;
   entry_type        caller_ff, caller_in;
   entry_type        best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             evv_ff, evv_in;
   logic [IDX_W-1:0] evi_ff, evi_in;
   logic             found_ff, found_in;
   logic             flag_ff, flag_in;
   logic             pass_b_ff, pass_b_in;
   logic [PID_BITS-1:0] next_pid_ff, next_pid_in;
   logic [6:0]       defprio_ff, defprio_in;
   logic [5:0]       init_ff, init_in;
   ppt_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_raw;
   entry_type              rd_e;
   ppt_pkg::store_ctl_type ctl;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_e;
   logic [NUM_SLOTS-1:0]   valid;

   ppt_store #(
      .NUM_SLOTS (NUM_SLOTS),
      .ENTRY_W   (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_e),
      .valid   (valid)
   );

   assign rd_e = entry_type'(rd_raw);

   logic             slot_in_range;
   logic [IDX_W-1:0] slot_idx;
   logic             caller_ok;
   logic             init_ok;
   logic             par_ok;
   logic [PAR_W-1:0] slot_par;
   logic [PAR_W-1:0] adopt_par;
   logic             ev_v;
   logic             pid_hit;

   always_comb begin
      slot_in_range = 32'(req_ff.slot) < NUM_SLOTS;
      slot_idx      = IDX_W'(req_ff.slot);
      slot_par      = PAR_W'(req_ff.slot);
      caller_ok     = slot_in_range && valid[slot_idx] &&
                      (rd_e.st == ppt_pkg::SLOT_RUNNING);
      init_ok       = 32'(init_ff) < NUM_SLOTS;
      par_ok        = caller_ff.parent < PAR_W'(NUM_SLOTS);
      adopt_par     = init_ok ? PAR_W'(init_ff) : PAR_W'(NUM_SLOTS);
      ev_v          = evv_ff && valid[evi_ff];
      pid_hit       = 32'(rd_e.pid) == 32'(req_ff.target_pid);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      caller_in    = caller_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      cnt_in       = cnt_ff;
      evv_in       = 1'b0;
      evi_in       = evi_ff;
      found_in     = found_ff;
      flag_in      = flag_ff;
      pass_b_in    = pass_b_ff;
      next_pid_in  = next_pid_ff;
      defprio_in   = defprio_ff;
      init_in      = init_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff[IDX_W-1:0];
      ctl          = '0;
      wr_addr      = evi_ff;
      wr_e         = rd_e;

      if (csr_write) begin
         case (csr_index)
            ppt_pkg::CSR_DEFAULT_PRIORITY: defprio_in = csr_wdata;
            ppt_pkg::CSR_INIT_SLOT:        init_in    = csr_wdata[5:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(req_payload.slot);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            caller_in = rd_e;
            cnt_in    = '0;
            found_in  = 1'b0;
            flag_in   = 1'b0;
            pass_b_in = 1'b0;
            rsp_in    = '0;
            rsp_in.status = ppt_pkg::STAT_FAIL;
            state_in  = S_DONE;
            wr_addr   = slot_idx;
            wr_e      = rd_e;
            case (req_ff.action)
               ppt_pkg::ACT_CREATE: begin
                  if (!req_ff.has_parent || (slot_in_range && valid[slot_idx])) begin
                     state_in = S_SCAN;
                  end
               end
               ppt_pkg::ACT_SCHEDULE, ppt_pkg::ACT_WAKEUP, ppt_pkg::ACT_KILL: begin
                  state_in = S_SCAN;
               end
               ppt_pkg::ACT_SETPRIO: begin
                  if (!req_ff.new_priority[7]) begin
                     state_in = S_SCAN;
                  end
               end
               ppt_pkg::ACT_YIELD: begin
                  if (caller_ok) begin
                     wr_e.st       = ppt_pkg::SLOT_RUNNABLE;
                     ctl.wr_en     = 1'b1;
                     rsp_in.status = ppt_pkg::STAT_OK;
                  end
               end
               ppt_pkg::ACT_SLEEP: begin
                  if (caller_ok) begin
                     wr_e.st       = ppt_pkg::SLOT_SLEEPING;
                     wr_e.chan     = req_ff.channel;
                     ctl.wr_en     = 1'b1;
                     rsp_in.status = ppt_pkg::STAT_SLEEPING;
                  end
               end
               ppt_pkg::ACT_EXIT: begin
                  if (caller_ok) begin
                     if (req_ff.slot == init_ff) begin
                        rsp_in.status = ppt_pkg::STAT_INIT_EXIT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               end
               ppt_pkg::ACT_WAIT: begin
                  if (caller_ok) begin
                     state_in = S_SCAN;
                  end
               end
               default: ;
            endcase
            if (state_in == S_DONE) begin
               rsp_valid_in = 1'b1;
            end
         end
         S_SCAN: begin
            if (cnt_ff < CNT_W'(NUM_SLOTS)) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               evv_in = 1'b1;
               evi_in = cnt_ff[IDX_W-1:0];
            end else if (!evv_ff) begin
               state_in = S_FINAL;
            end
            if (evv_ff) begin
               case (req_ff.action)
                  ppt_pkg::ACT_CREATE: begin
                     if (!found_ff && !valid[evi_ff]) begin
                        wr_e.st     = ppt_pkg::SLOT_RUNNABLE;
                        wr_e.pid    = next_pid_ff;
                        wr_e.prio   = defprio_ff;
                        wr_e.parent = req_ff.has_parent ? slot_par : PAR_W'(NUM_SLOTS);
                        wr_e.chan   = '0;
                        wr_e.killed = 1'b0;
                        ctl.wr_en     = 1'b1;
                        ctl.set_valid = 1'b1;
                        found_in    = 1'b1;
                        best_idx_in = evi_ff;
                        best_in     = wr_e;
                        next_pid_in = (next_pid_ff == PID_MAX) ? PID_BITS'(1)
                                                               : next_pid_ff + 1'b1;
                     end
                  end
                  ppt_pkg::ACT_SCHEDULE: begin
                     if (ev_v && rd_e.st == ppt_pkg::SLOT_RUNNABLE &&
                         (!found_ff || rd_e.prio < best_ff.prio)) begin
                        found_in    = 1'b1;
                        best_idx_in = evi_ff;
                        best_in     = rd_e;
                     end
                  end
                  ppt_pkg::ACT_WAKEUP: begin
                     if (ev_v && rd_e.st == ppt_pkg::SLOT_SLEEPING &&
                         rd_e.chan == req_ff.channel) begin
                        wr_e.st   = ppt_pkg::SLOT_RUNNABLE;
                        ctl.wr_en = 1'b1;
                     end
                  end
                  ppt_pkg::ACT_KILL: begin
                     if (!found_ff && ev_v && pid_hit) begin
                        wr_e.killed = 1'b1;
                        if (rd_e.st == ppt_pkg::SLOT_SLEEPING) begin
                           wr_e.st = ppt_pkg::SLOT_RUNNABLE;
                        end
                        ctl.wr_en = 1'b1;
                        found_in  = 1'b1;
                     end
                  end
                  ppt_pkg::ACT_SETPRIO: begin
                     if (!found_ff && ev_v && pid_hit) begin
                        wr_e.prio = req_ff.new_priority[6:0];
                        ctl.wr_en = 1'b1;
                        found_in  = 1'b1;
                     end
                  end
                  ppt_pkg::ACT_EXIT: begin
                     if (!pass_b_ff) begin
                        if (ev_v && rd_e.parent == slot_par) begin
                           wr_e.parent = adopt_par;
                           ctl.wr_en   = 1'b1;
                           if (init_ok && rd_e.st == ppt_pkg::SLOT_ZOMBIE) begin
                              flag_in = 1'b1;
                           end
                        end
                     end else if (ev_v && rd_e.st == ppt_pkg::SLOT_SLEEPING &&
                                  ((par_ok && rd_e.chan == 16'(caller_ff.parent)) ||
                                   (flag_ff && rd_e.chan == 16'(init_ff)))) begin
                        wr_e.st   = ppt_pkg::SLOT_RUNNABLE;
                        ctl.wr_en = 1'b1;
                     end
                  end
                  ppt_pkg::ACT_WAIT: begin
                     if (!found_ff && ev_v && rd_e.parent == slot_par) begin
                        flag_in = 1'b1;
                        if (rd_e.st == ppt_pkg::SLOT_ZOMBIE) begin
                           ctl.clr_valid = 1'b1;
                           found_in      = 1'b1;
                           best_idx_in   = evi_ff;
                           best_in       = rd_e;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FINAL: begin
            state_in     = S_DONE;
            rsp_valid_in = 1'b1;
            wr_addr      = best_idx_ff;
            wr_e         = best_ff;
            case (req_ff.action)
               ppt_pkg::ACT_CREATE, ppt_pkg::ACT_WAIT, ppt_pkg::ACT_SCHEDULE: begin
                  if (found_ff) begin
                     rsp_in.status      = ppt_pkg::STAT_OK;
                     rsp_in.result_slot = 6'(best_idx_ff);
                     rsp_in.result_pid  = 16'(best_ff.pid);
                     if (req_ff.action == ppt_pkg::ACT_SCHEDULE) begin
                        wr_e.st   = ppt_pkg::SLOT_RUNNING;
                        ctl.wr_en = 1'b1;
                     end
                  end else if (req_ff.action == ppt_pkg::ACT_WAIT &&
                               flag_ff && !caller_ff.killed) begin
                     wr_addr       = slot_idx;
                     wr_e          = caller_ff;
                     wr_e.st       = ppt_pkg::SLOT_SLEEPING;
                     wr_e.chan     = 16'(req_ff.slot);
                     ctl.wr_en     = 1'b1;
                     rsp_in.status = ppt_pkg::STAT_SLEEPING;
                  end
               end
               ppt_pkg::ACT_WAKEUP: begin
                  rsp_in.status = ppt_pkg::STAT_OK;
               end
               ppt_pkg::ACT_KILL, ppt_pkg::ACT_SETPRIO: begin
                  if (found_ff) begin
                     rsp_in.status = ppt_pkg::STAT_OK;
                  end
               end
               ppt_pkg::ACT_EXIT: begin
                  if (!pass_b_ff) begin
                     pass_b_in    = 1'b1;
                     cnt_in       = '0;
                     state_in     = S_SCAN;
                     rsp_valid_in = 1'b0;
                  end else begin
                     wr_addr       = slot_idx;
                     wr_e          = caller_ff;
                     wr_e.st       = ppt_pkg::SLOT_ZOMBIE;
                     if (caller_ff.parent == slot_par) begin
                        wr_e.parent = adopt_par;
                     end
                     ctl.wr_en     = 1'b1;
                     rsp_in.status = ppt_pkg::STAT_OK;
                  end
               end
               default: ;
            endcase
         end
         S_DONE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         evv_ff       <= 1'b0;
         next_pid_ff  <= PID_BITS'(1);
         defprio_ff   <= ppt_pkg::DEFAULT_PRIORITY_RESET;
         init_ff      <= ppt_pkg::INIT_SLOT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         evv_ff       <= evv_in;
         next_pid_ff  <= next_pid_in;
         defprio_ff   <= defprio_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      caller_ff   <= caller_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      cnt_ff      <= cnt_in;
      evi_ff      <= evi_in;
      found_ff    <= found_in;
      flag_ff     <= flag_in;
      pass_b_ff   <= pass_b_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/ppt_checker.sv @@
// Port-level checks for the priority process table, bound to the top level.
// Depends on ppt_pkg and priority_process_table.
`default_nettype none
module ppt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ppt_pkg::rsp_type rsp_payload
);

   a_busy_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("Input taken while a result word is pending.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input ready again directly after acceptance.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("Stalled result word changed or dropped.");

   a_empty_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ppt_pkg::STAT_OK) |->
      (rsp_payload.result_slot == 6'd0 && rsp_payload.result_pid == 16'd0))
      else $error("Result fields set on a non-ok word.");

endmodule

bind priority_process_table ppt_checker u_ppt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
